// ===== hdl/telemetry_sensor_responder_assert.svh =====
// Assertion macros shared by the telemetry sensor responder
`ifndef TELEMETRY_SENSOR_RESPONDER_ASSERT_SVH
`define TELEMETRY_SENSOR_RESPONDER_ASSERT_SVH

// Property that holds in every cycle outside reset
`define TSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define TSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/tsr_pkg.sv =====
package tsr_pkg;

  localparam logic [7:0] FrameStart = 8'h7e;
  localparam logic [7:0] EscByte    = 8'h7d;
  localparam logic [7:0] EscStart   = 8'h5e;
  localparam logic [7:0] EscEsc     = 8'h5d;
  localparam logic [7:0] DataHead   = 8'h10;
  localparam logic [7:0] CmdOther   = 8'd5;

  localparam logic [1:0] RegPollId   = 2'd0;
  localparam logic [1:0] RegCmdId    = 2'd1;
  localparam logic [1:0] RegDelay    = 2'd2;
  localparam logic [1:0] RegPrefixCd = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_BUILD,
    ST_SEND,
    ST_CMD
  } state_e;

  function automatic logic [15:0] slot_id(input logic [3:0] s);
    logic [15:0] r;
    begin
      unique case (s)
        4'd0, 4'd1: r = 16'h0800;
        4'd2: r = 16'h0820;
        4'd3: r = 16'h0830;
        4'd4: r = 16'h0840;
        4'd5, 4'd6: r = 16'h0850;
        4'd7: r = 16'h5200;
        4'd8: r = 16'h5210;
        4'd9: r = 16'h5220;
        4'd10: r = 16'h5230;
        4'd11: r = 16'h5240;
        4'd12: r = 16'h5250;
        4'd13: r = 16'h5260;
        4'd14: r = 16'h5270;
        default: r = 16'h5280;
      endcase
      return r;
    end
  endfunction

  function automatic logic [13:0] slot_period(input logic [3:0] s);
    logic [13:0] r;
    begin
      unique case (s)
        4'd5: r = 14'd10000;
        4'd11: r = 14'd5000;
        default: r = 14'd1000;
      endcase
      return r;
    end
  endfunction

  // Checksum over seven bytes packed low byte first
  function automatic logic [7:0] csum7(input logic [55:0] f);
    logic [10:0] t;
    logic [2:0] hi;
    logic [10:0] u;
    begin
      t = '0;
      for (int i = 0; i < 7; i++) t = t + {3'd0, f[8*i +: 8]};
      hi = (t[10:8] > 3'd7) ? 3'd7 : t[10:8];
      u = t + {8'd0, hi};
      return 8'hff - u[7:0];
    end
  endfunction

endpackage

// ===== hdl/tsr_if.sv =====
interface tsr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  frame_len;
  logic [63:0] frame_head;
  logic [15:0] frame_tail;
  logic [31:0] now_ms;
  logic [3:0]  metric_slot;
  logic [31:0] metric_value;
  modport source (output valid, kind, frame_len, frame_head, frame_tail, now_ms,
                  metric_slot, metric_value, input ready);
  modport sink (input valid, kind, frame_len, frame_head, frame_tail, now_ms,
                metric_slot, metric_value, output ready);
endinterface

interface tsr_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  tx_byte;
  logic        last_byte;
  logic [7:0]  command_code;
  logic [31:0] new_prefix;
  modport source (output valid, result_kind, tx_byte, last_byte, command_code,
                  new_prefix, input ready);
  modport sink (input valid, result_kind, tx_byte, last_byte, command_code,
                new_prefix, output ready);
endinterface

// ===== hdl/telemetry_sensor_responder.sv =====
// Smart-Port style telemetry sensor responder.
// Input channel in_i carries received frames, idle calls (frame_len 0) and
// metric writes (kind 1). Output channel out_o carries transmitted reply
// bytes (byte-stuffed, last_byte on the final one) and command results.
// APB port: registers poll id, command id, reply delay, prefix code at
// byte addresses 0, 4, 8, 12.
// Throughput: one item at a time. A metric write or plain frame completes on
// acceptance; a poll walks the slot table one slot per cycle through
// one shared subtract-and-compare unit, then builds the reply frame. A
// command or a reply trigger presents its first result the cycle
// after acceptance. A reply run emits one byte per accepted output cycle,
// up to 16. Each result is held in registered state; if the receiver
// stalls, the sequencer holds until it is taken, and in_i stays low-ready
// meanwhile. Reset clears metrics, send times, the reply arm and count,
// sets the current slot to NUM_METRICS-1 and restores register reset values.
`include "telemetry_sensor_responder_assert.svh"

module telemetry_sensor_responder #(
  parameter int NUM_METRICS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsr_in_if.sink      in_i,
  tsr_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = 4;
  localparam logic [SW-1:0] LastSlot = SW'(NUM_METRICS - 1);

  // configuration
  logic [7:0] poll_id_q, cmd_id_q, prefix_cd_q;
  logic [4:0] delay_q;
  logic       wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_id_q   <= 8'hf2;
      cmd_id_q    <= 8'h53;
      delay_q     <= 5'd25;
      prefix_cd_q <= 8'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        tsr_pkg::RegPollId:   poll_id_q   <= pwdata[7:0];
        tsr_pkg::RegCmdId:    cmd_id_q    <= pwdata[7:0];
        tsr_pkg::RegDelay:    delay_q     <= pwdata[4:0];
        default:              prefix_cd_q <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tsr_pkg::RegPollId:  prdata = {24'd0, poll_id_q};
      tsr_pkg::RegCmdId:   prdata = {24'd0, cmd_id_q};
      tsr_pkg::RegDelay:   prdata = {27'd0, delay_q};
      default:             prdata = {24'd0, prefix_cd_q};
    endcase
  end

  // state
  tsr_pkg::state_e state_q, state_d;
  logic [31:0] metric_q [NUM_METRICS];
  logic [31:0] sent_q [NUM_METRICS];
  logic [SW-1:0] cur_q, cur_d, scan_q, scan_d, start_q, start_d;
  logic [63:0] frame_q, frame_d;
  logic [4:0]  count_q, count_d;
  logic        armed_q, armed_d;
  logic [31:0] now_q, now_d;
  logic [3:0]  idx_q, idx_d;      // reply byte index
  logic        esc_q, esc_d;      // second half of an escape pair
  logic [31:0] pfx_q, pfx_d;
  logic        setp_q, setp_d;
  logic        found_q, found_d;

  logic        in_fire, out_fire;
  logic [7:0]  b [10];
  logic        is_poll, is_cmd, cmd_ok;
  logic [55:0] cmd_bytes;
  logic [SW-1:0] nxt;
  logic [31:0] age;
  logic        due;
  logic [7:0]  cur_byte;
  logic        need_esc;
  logic [55:0] f7;
  logic [15:0] id;
  logic [31:0] v;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  always_comb begin
    for (int i = 0; i < 8; i++) b[i] = in_i.frame_head[8*i +: 8];
    b[8] = in_i.frame_tail[7:0];
    b[9] = in_i.frame_tail[15:8];
  end
  assign cmd_bytes = {in_i.frame_tail[7:0], in_i.frame_head[63:16]};
  assign is_poll = in_i.frame_len == 4'd2 && b[0] == tsr_pkg::FrameStart
                   && b[1] == poll_id_q;
  assign is_cmd  = in_i.frame_len == 4'd10 && b[0] == tsr_pkg::FrameStart
                   && b[1] == cmd_id_q;
  assign cmd_ok  = tsr_pkg::csum7(cmd_bytes) == b[9];

  // shared due unit: one slot per cycle
  assign nxt = (scan_q == LastSlot) ? '0 : scan_q + 1'b1;
  assign age = now_q - sent_q[scan_q];
  assign due = age > {18'd0, tsr_pkg::slot_period(scan_q)};

  assign id = tsr_pkg::slot_id(cur_q);
  assign v  = metric_q[cur_q];
  assign f7 = {v, id, tsr_pkg::DataHead};

  assign cur_byte = frame_q[{idx_q[2:0], 3'b000} +: 8];
  assign need_esc = cur_byte == tsr_pkg::FrameStart || cur_byte == tsr_pkg::EscByte;

  always_comb begin
    state_d = state_q; cur_d = cur_q; scan_d = scan_q; start_d = start_q;
    frame_d = frame_q; count_d = count_q; armed_d = armed_q; now_d = now_q;
    idx_d = idx_q; esc_d = esc_q; pfx_d = pfx_q; setp_d = setp_q;
    found_d = found_q;
    in_i.ready = 1'b0;
    out_o.valid = 1'b0;
    out_o.result_kind = 1'b0;
    out_o.tx_byte = '0;
    out_o.last_byte = 1'b0;
    out_o.command_code = '0;
    out_o.new_prefix = '0;
    unique case (state_q)
      tsr_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_fire && !in_i.kind) begin
          if (is_poll) begin
            now_d   = in_i.now_ms;
            start_d = cur_q;
            scan_d  = (cur_q == LastSlot) ? '0 : cur_q + 1'b1;
            found_d = 1'b0;
            state_d = tsr_pkg::ST_SEARCH;
          end else if (is_cmd) begin
            if (cmd_ok) begin
              setp_d  = b[3] == 8'hff && b[4] == 8'h00;
              pfx_d   = {b[8], b[7], b[6], b[5]};
              state_d = tsr_pkg::ST_CMD;
            end
          end else if (armed_q) begin
            if (count_q == delay_q) begin
              idx_d = '0; esc_d = 1'b0;
              armed_d = 1'b0;
              state_d = tsr_pkg::ST_SEND;
            end else begin
              count_d = count_q + 5'd1;
            end
          end
        end
      end
      tsr_pkg::ST_SEARCH: begin
        if (scan_q == start_q) begin
          state_d = tsr_pkg::ST_BUILD;
        end else if (due) begin
          cur_d = scan_q; found_d = 1'b1;
          state_d = tsr_pkg::ST_BUILD;
        end else begin
          scan_d = nxt;
        end
      end
      tsr_pkg::ST_BUILD: begin
        frame_d = found_q ? {tsr_pkg::csum7(f7), f7} : {8'hff, 56'd0};
        armed_d = 1'b1;
        count_d = '0;
        state_d = tsr_pkg::ST_IDLE;
      end
      tsr_pkg::ST_SEND: begin
        out_o.valid = 1'b1;
        if (need_esc && !esc_q) begin
          out_o.tx_byte = tsr_pkg::EscByte;
        end else begin
          out_o.tx_byte = !need_esc ? cur_byte :
                          (cur_byte == tsr_pkg::FrameStart) ? tsr_pkg::EscStart
                                                           : tsr_pkg::EscEsc;
          out_o.last_byte = idx_q == 4'd7;
        end
        if (out_fire) begin
          if (need_esc && !esc_q) esc_d = 1'b1;
          else begin
            esc_d = 1'b0;
            idx_d = idx_q + 4'd1;
            if (idx_q == 4'd7) state_d = tsr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        out_o.valid = 1'b1;
        out_o.result_kind = 1'b1;
        out_o.command_code = setp_q ? prefix_cd_q : tsr_pkg::CmdOther;
        out_o.new_prefix = setp_q ? pfx_q : '0;
        if (out_fire) state_d = tsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsr_pkg::ST_IDLE;
      cur_q   <= LastSlot;
      count_q <= '0;
      armed_q <= 1'b0;
      idx_q   <= '0;
      esc_q   <= 1'b0;
      for (int i = 0; i < NUM_METRICS; i++) begin
        metric_q[i] <= '0;
        sent_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      count_q <= count_d;
      armed_q <= armed_d;
      idx_q   <= idx_d;
      esc_q   <= esc_d;
      if (in_fire && in_i.kind && {1'b0, in_i.metric_slot} < 5'(NUM_METRICS))
        metric_q[in_i.metric_slot[SW-1:0]] <= in_i.metric_value;
      if (state_q == tsr_pkg::ST_SEARCH && scan_q != start_q && due)
        sent_q[scan_q] <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    start_q <= start_d;
    frame_q <= frame_d;
    now_q   <= now_d;
    pfx_q   <= pfx_d;
    setp_q  <= setp_d;
    found_q <= found_d;
  end

  `TSR_ASSERT(a_ready_idle, clk_i, rst_ni,
    !in_i.ready || state_q == tsr_pkg::ST_IDLE)
  `TSR_ASSERT(a_out_busy, clk_i, rst_ni,
    !out_o.valid || state_q == tsr_pkg::ST_SEND || state_q == tsr_pkg::ST_CMD)
  `TSR_ASSERT_NEXT(a_build_arms, clk_i, rst_ni,
    state_q == tsr_pkg::ST_BUILD, armed_q && count_q == 5'd0)
  `TSR_ASSERT_NEXT(a_last_ends, clk_i, rst_ni,
    out_fire && out_o.last_byte, state_q == tsr_pkg::ST_IDLE)

endmodule

// ===== verif/tsr_scoreboard.sv =====
`timescale 1ns / 1ps

class tsr_scoreboard;
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [7:0]  command_code;
    logic [31:0] new_prefix;
  } sensor_result_t;

  // register copies
  logic [7:0] poll_id;
  logic [7:0] cmd_id;
  logic [4:0] delay;
  logic [7:0] prefix_code;

  // sensor state
  logic [31:0] metric_vals[12];
  logic [31:0] sent_at[12];
  int unsigned served_slot;
  logic [63:0] armed_frame;
  logic [4:0]  armed_count;
  bit          armed;

  sensor_result_t pending_results[$];
  int mismatches;

  function new();
    mismatches = 0;
    poll_id = 8'hf2;
    cmd_id = 8'h53;
    delay = 5'd25;
    prefix_code = 8'd1;
    for (int i = 0; i < 12; i++) begin
      metric_vals[i] = '0;
      sent_at[i] = '0;
    end
    served_slot = 11;
    armed_frame = '0;
    armed_count = '0;
    armed = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] v);
    case (idx)
      tsr_pkg::RegPollId:   poll_id = v[7:0];
      tsr_pkg::RegCmdId:    cmd_id = v[7:0];
      tsr_pkg::RegDelay:    delay = v[4:0];
      tsr_pkg::RegPrefixCd: prefix_code = v[7:0];
      default: ;
    endcase
  endfunction

  static function logic [15:0] id_of(int s);
    logic [15:0] ids[12] = '{16'h0800, 16'h0800, 16'h0820, 16'h0830, 16'h0840,
      16'h0850, 16'h0850, 16'h5200, 16'h5210, 16'h5220, 16'h5230, 16'h5240};
    return ids[s];
  endfunction

  static function logic [31:0] period_of(int s);
    if (s == 5) return 32'd10000;
    if (s == 11) return 32'd5000;
    return 32'd1000;
  endfunction

  static function logic [7:0] frame_sum(logic [55:0] f);
    int unsigned t;
    int unsigned hi;
    t = 0;
    for (int i = 0; i < 7; i++) t += f[8*i +: 8];
    hi = t >> 8;
    if (hi > 7) hi = 7;
    t += hi;
    return 8'(8'hff - t[7:0]);
  endfunction

  function void push_byte(logic [7:0] b, logic lst);
    sensor_result_t r;
    r = '0;
    r.tx_byte = b;
    r.last_byte = lst;
    pending_results.push_back(r);
  endfunction

  // note an accepted input and predict its results
  function void note_item(logic kind, logic [3:0] flen, logic [63:0] head,
                          logic [15:0] tail, logic [31:0] now,
                          logic [3:0] slot, logic [31:0] val);
    logic [79:0] fb;
    logic [7:0] b[10];
    logic [7:0] c;
    sensor_result_t r;
    int unsigned s;
    int found;
    if (kind) begin
      if (slot < 12) metric_vals[slot] = val;
      return;
    end
    fb = {tail, head};
    for (int i = 0; i < 10; i++) b[i] = fb[8*i +: 8];
    if (flen == 2 && b[0] == tsr_pkg::FrameStart && b[1] == poll_id) begin
      found = -1;
      s = (served_slot + 1) % 12;
      while (s != served_slot) begin
        if (32'(now - sent_at[s]) > period_of(s)) begin
          found = s;
          break;
        end
        s = (s + 1) % 12;
      end
      if (found < 0) armed_frame = 64'hff << 56;
      else begin
        served_slot = found;
        armed_frame[55:0] = {metric_vals[found], id_of(found), tsr_pkg::DataHead};
        armed_frame[63:56] = frame_sum(armed_frame[55:0]);
        sent_at[found] = now;
      end
      armed = 1;
      armed_count = 0;
      return;
    end
    if (flen == 10 && b[0] == tsr_pkg::FrameStart && b[1] == cmd_id) begin
      if (frame_sum(fb[71:16]) == b[9]) begin
        r = '0;
        r.result_kind = 1;
        if (b[3] == 8'hff && b[4] == 8'h00) begin
          r.command_code = prefix_code;
          r.new_prefix = fb[71:40];
        end else r.command_code = tsr_pkg::CmdOther;
        pending_results.push_back(r);
      end
      return;
    end
    if (armed) begin
      if (armed_count == delay) begin
        for (int i = 0; i < 8; i++) begin
          c = armed_frame[8*i +: 8];
          if (c == tsr_pkg::FrameStart || c == tsr_pkg::EscByte) begin
            push_byte(tsr_pkg::EscByte, 0);
            push_byte(c == tsr_pkg::FrameStart ? tsr_pkg::EscStart : tsr_pkg::EscEsc,
                      i == 7);
          end else push_byte(c, i == 7);
        end
        armed = 0;
      end else armed_count = armed_count + 1;
    end
  endfunction

  // compare one accepted result with the oldest expectation
  function void check_result(sensor_result_t got);
    sensor_result_t exp_r;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending_results.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: kind %0d/%0d byte %h/%h last %0d/%0d code %h/%h prefix %h/%h",
                 exp_r.result_kind, got.result_kind, exp_r.tx_byte, got.tx_byte,
                 exp_r.last_byte, got.last_byte, exp_r.command_code, got.command_code,
                 exp_r.new_prefix, got.new_prefix);
    end
  endfunction
endclass

// ===== verif/tb_telemetry_sensor_responder.sv =====
`timescale 1ns / 1ps

module tb_telemetry_sensor_responder;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tsr_in_if in_ch();
  tsr_out_if out_ch();

  telemetry_sensor_responder uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tsr_scoreboard sensor_sb = new();
  bit quiet_phase = 0;
  bit hold_off = 0;
  logic [31:0] clock_ms = 32'd5;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.kind = 0; in_ch.frame_len = 0; in_ch.frame_head = '0;
    in_ch.frame_tail = '0; in_ch.now_ms = '0; in_ch.metric_slot = '0;
    in_ch.metric_value = '0; out_ch.ready = 0;
  end

  // watchdog
  initial begin
    #4000000;
    $display("telemetry_sensor_responder regression: fail");
    $finish;
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sensor_sb.check_result({out_ch.result_kind, out_ch.tx_byte, out_ch.last_byte,
                              out_ch.command_code, out_ch.new_prefix});
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 6);
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1;
        @(posedge clk_i);
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] v);
    in_ch.valid <= 0;
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sensor_sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic send_item(logic kind, logic [3:0] flen, logic [63:0] head,
                           logic [15:0] tail, logic [3:0] slot, logic [31:0] val);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1; in_ch.kind <= kind; in_ch.frame_len <= flen;
    in_ch.frame_head <= head; in_ch.frame_tail <= tail; in_ch.now_ms <= clock_ms;
    in_ch.metric_slot <= slot; in_ch.metric_value <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    sensor_sb.note_item(kind, flen, head, tail, clock_ms, slot, val);
  endtask

  task automatic send_poll(logic [7:0] id);
    send_item(0, 4'd2, {$urandom, 16'($urandom), id, tsr_pkg::FrameStart},
              16'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic send_idle(int n);
    repeat (n) send_item(0, 4'd0, {$urandom, $urandom}, 16'($urandom), 4'($urandom),
                         $urandom);
  endtask

  // command with a valid or, with bad_sum, corrupted checksum, optionally set-prefix
  task automatic send_command(bit set_prefix, bit bad_sum);
    logic [79:0] fb;
    fb = {$urandom, $urandom, 16'($urandom)};
    fb[7:0] = tsr_pkg::FrameStart;
    fb[15:8] = sensor_sb.cmd_id;
    if (set_prefix) begin
      fb[31:24] = 8'hff;
      fb[39:32] = 8'h00;
    end
    fb[79:72] = sensor_sb.frame_sum(fb[71:16]) ^ {7'd0, bad_sum};
    send_item(0, 4'd10, fb[63:0], fb[79:64], 4'($urandom), $urandom);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sensor_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // poll cycle: poll, idle calls up to the delay, then the reply
  task automatic poll_round();
    send_poll(sensor_sb.poll_id);
    send_idle(int'(sensor_sb.delay) + 1);
  endtask

  initial begin
    int pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: short delay, extreme values, escapes, commands
    apb_write(tsr_pkg::RegDelay, 32'd0);
    send_item(1, 4'd0, '0, '0, 4'd1, 32'h7e7d_ffff);
    send_item(1, 4'd0, '0, '0, 4'd0, 32'h0000_0000);
    send_item(1, 4'd0, '0, '0, 4'd15, 32'hffff_ffff);
    send_item(1, 4'd0, '0, '0, 4'd12, 32'h1234_5678);
    clock_ms = 32'd20000;
    poll_round();
    poll_round();
    poll_round();
    send_poll(sensor_sb.poll_id); // another poll at the same time: later slots are still due
    clock_ms = 32'd20001;
    send_poll(sensor_sb.poll_id); // poll while armed
    send_item(0, 4'd15, '1, '1, 4'd0, 0);
    send_command(1, 0);
    send_command(0, 0);
    send_command(1, 1);
    send_item(0, 4'd10, 64'hffff_ffff_ffff_ffff, 16'hffff, 0, 0);
    clock_ms = 32'hffff_fff0;
    poll_round();
    drain();

    apb_write(tsr_pkg::RegPollId, 32'h0000_0000);
    apb_write(tsr_pkg::RegCmdId, 32'h0000_00ff);
    apb_write(tsr_pkg::RegPrefixCd, 32'h0000_00ff);
    apb_write(tsr_pkg::RegDelay, 32'd31);
    clock_ms = 32'd100;
    poll_round();
    send_command(1, 0);
    drain();

    // random phases with different settings
    for (int phase = 0; phase < 4; phase++) begin
      apb_write(tsr_pkg::RegPollId, phase == 3 ? 32'hf2 : $urandom);
      apb_write(tsr_pkg::RegCmdId, $urandom);
      apb_write(tsr_pkg::RegPrefixCd, phase == 3 ? 32'd0 : $urandom);
      apb_write(tsr_pkg::RegDelay, phase == 0 ? 32'd3 : $urandom_range(0, 6));
      if (phase == 3) quiet_phase = 1;
      if (phase == 1) hold_off = 1;
      for (int n = 0; n < 28; n++) begin
        clock_ms = clock_ms + $urandom_range(0, 1500);
        pick = $urandom_range(0, 9);
        if (pick < 5) send_poll(sensor_sb.poll_id);
        else if (pick < 6) send_command(1'($urandom_range(0, 1)),
                                        $urandom_range(0, 3) == 0);
        else if (pick < 7) send_item(1, 4'($urandom_range(0, 15)), {$urandom, $urandom},
                                     16'($urandom), 4'($urandom), $urandom);
        else if (pick < 8) send_item(0, 4'($urandom), {$urandom, $urandom},
                                     16'($urandom), 4'($urandom), $urandom);
        else send_idle(1);
        if (pick < 5) send_idle(int'(sensor_sb.delay) + int'($urandom_range(0, 2)));
      end
      drain();
    end

    if (sensor_sb.mismatches == 0 && sensor_sb.pending_results.size() == 0)
      $display("telemetry_sensor_responder regression: pass");
    else
      $display("telemetry_sensor_responder regression: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tsr_pkg.sv
hdl/tsr_if.sv
hdl/telemetry_sensor_responder.sv
verif/tsr_scoreboard.sv
verif/tb_telemetry_sensor_responder.sv
